@@ sv/prd_pkg.sv @@
`timescale 1ns / 1ps
package prd_pkg;

  localparam logic [7:0] RUN_MARK     = 8'hC0;
  localparam logic [5:0] RUN_LEN_MASK = 6'h3F;

  localparam logic [2:0] CFG_DEPTH_CODE      = 3'd0;
  localparam logic [2:0] CFG_THREE_PLANES    = 3'd1;
  localparam logic [2:0] CFG_BYTES_PER_PLANE = 3'd2;
  localparam logic [2:0] CFG_IMAGE_WIDTH     = 3'd3;
  localparam logic [2:0] CFG_IMAGE_HEIGHT    = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [7:0]  pixel_a;
    logic [7:0]  pixel_b;
    logic [7:0]  pixel_c;
    logic [7:0]  pixel_d;
    logic [7:0]  pixel_e;
    logic [7:0]  pixel_f;
    logic [7:0]  pixel_g;
    logic [7:0]  pixel_h;
    logic [3:0]  pixel_count;
    logic [11:0] x_start;
    logic [11:0] row;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
    logic       is_marker;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  depth_code;
    logic        three_planes;
    logic [12:0] bytes_per_plane;
    logic [12:0] image_width;
    logic [12:0] image_height;
  } cfg_t;

endpackage

@@ sv/prd_ram.sv @@
`timescale 1ns / 1ps
module prd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/prd_fifo.sv @@
`timescale 1ns / 1ps
module prd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign dout    = mem[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

endmodule

@@ sv/prd_front.sv @@
`timescale 1ns / 1ps
module prd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  prd_pkg::in_t  stream,
  input  logic          cmd_pop,
  output logic          cmd_empty,
  output prd_pkg::cmd_t cmd
);
  import prd_pkg::*;

  localparam int CMD_DEPTH = 4;

  cmd_t cmd_in;

  always_comb begin
    cmd_in.data_byte   = stream.data_byte;
    cmd_in.frame_start = stream.frame_start;
    cmd_in.is_marker   = ((stream.data_byte & RUN_MARK) == RUN_MARK);
  end

  prd_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (cmd_in),
    .full (full),
    .pop  (cmd_pop),
    .dout (cmd),
    .empty(cmd_empty)
  );

endmodule

@@ sv/prd_back.sv @@
`timescale 1ns / 1ps
module prd_back #(
  parameter int MAX_WIDTH       = 4096,
  parameter int MAX_PLANE_BYTES = 4096,
  parameter int MAX_HEIGHT      = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  prd_pkg::cfg_t cfg,
  input  logic          cmd_empty,
  input  prd_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output prd_pkg::out_t res
);
  import prd_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_BLUE = 2'd2;

  logic [1:0]  state, state_next;
  logic [5:0]  remaining, remaining_next;
  logic [7:0]  cur_byte, cur_byte_next;
  logic        run_pending, run_pending_next;
  logic [5:0]  run_length, run_length_next;
  logic [11:0] pos, pos_next;
  logic [1:0]  plane, plane_next;
  logic [12:0] rows_done, rows_done_next;
  logic        hold_valid, hold_valid_next;
  out_t        hold, hold_next;

  logic [12:0] eff_w, eff_h, eff_pb;
  logic [1:0]  planes;
  logic [11:0] row_val;

  logic [12:0] pos_inc;
  logic [11:0] pos_adv;
  logic [1:0]  plane_adv;
  logic [12:0] rows_adv;

  logic [3:0]  bits;
  logic [3:0]  ppb;
  logic [14:0] x_mono;
  logic [14:0] width_left;
  logic [3:0]  cnt;
  logic        mono_made;
  logic [7:0]  px [8];
  out_t        mono_res;

  logic        blue_made;
  out_t        blue_res;
  logic [7:0]  red_q, green_q;

  logic        place;
  logic        new_made;
  out_t        new_res;
  logic        pend_eff;
  logic [5:0]  rlen_eff;
  logic [12:0] rows_eff;

  logic [AW-1:0] ram_addr;
  logic          pos_in_ram;
  logic          red_we, green_we;

  assign eff_w = (32'(cfg.image_width) > MAX_WIDTH) ? 13'(MAX_WIDTH) : cfg.image_width;
  assign eff_h = (32'(cfg.image_height) > MAX_HEIGHT) ? 13'(MAX_HEIGHT) : cfg.image_height;

  always_comb begin
    if (cfg.bytes_per_plane == '0) begin
      eff_pb = 13'd1;
    end else if (32'(cfg.bytes_per_plane) > MAX_PLANE_BYTES) begin
      eff_pb = 13'(MAX_PLANE_BYTES);
    end else begin
      eff_pb = cfg.bytes_per_plane;
    end
  end

  assign planes  = cfg.three_planes ? 2'd3 : 2'd1;
  assign row_val = 12'(eff_h - 13'd1 - rows_done);

  // position advance after one placed byte
  assign pos_inc = {1'b0, pos} + 13'd1;

  always_comb begin
    pos_adv   = pos_inc[11:0];
    plane_adv = plane;
    rows_adv  = rows_done;
    if (pos_inc >= eff_pb) begin
      pos_adv   = '0;
      plane_adv = plane + 2'd1;
      if (plane_adv >= planes) begin
        plane_adv = '0;
        rows_adv  = rows_done + 13'd1;
      end
    end
  end

  // one-plane unpack, MSB first
  assign bits       = 4'd1 << cfg.depth_code;
  assign ppb        = 4'd8 >> cfg.depth_code;
  assign x_mono     = {3'b0, pos} << (2'd3 - cfg.depth_code);
  assign mono_made  = (x_mono < 15'(eff_w));
  assign width_left = 15'(eff_w) - x_mono;
  assign cnt        = (width_left > 15'(ppb)) ? ppb : width_left[3:0];

  always_comb begin : unpack
    logic [7:0] shifted;
    logic [7:0] v;
    for (int k = 0; k < 8; k++) begin
      shifted = cur_byte << (k * bits);
      v       = shifted >> (4'd8 - bits);
      px[k]   = (4'(k) < cnt) ? v : '0;
    end
  end

  always_comb begin
    mono_res.pixel_a     = px[0];
    mono_res.pixel_b     = px[1];
    mono_res.pixel_c     = px[2];
    mono_res.pixel_d     = px[3];
    mono_res.pixel_e     = px[4];
    mono_res.pixel_f     = px[5];
    mono_res.pixel_g     = px[6];
    mono_res.pixel_h     = px[7];
    mono_res.pixel_count = cnt;
    mono_res.x_start     = x_mono[11:0];
    mono_res.row         = row_val;
    mono_res.last_of_run = 1'b0;
  end

  assign blue_made = ({1'b0, pos} < eff_w);

  always_comb begin
    blue_res             = '0;
    blue_res.pixel_a     = red_q;
    blue_res.pixel_b     = green_q;
    blue_res.pixel_c     = cur_byte;
    blue_res.pixel_count = 4'd1;
    blue_res.x_start     = pos;
    blue_res.row         = row_val;
  end

  // sequencer
  always_comb begin
    state_next       = state;
    remaining_next   = remaining;
    cur_byte_next    = cur_byte;
    run_pending_next = run_pending;
    run_length_next  = run_length;
    pos_next         = pos;
    plane_next       = plane;
    rows_done_next   = rows_done;
    hold_valid_next  = hold_valid;
    hold_next        = hold;
    res_push         = 1'b0;
    res              = hold;
    cmd_pop          = 1'b0;
    place            = 1'b0;
    new_made         = 1'b0;
    new_res          = mono_res;
    pend_eff         = cmd.frame_start ? 1'b0 : run_pending;
    rlen_eff         = cmd.frame_start ? '0 : run_length;
    rows_eff         = cmd.frame_start ? '0 : rows_done;

    unique case (state)
      ST_IDLE: begin
        if (hold_valid && !res_full) begin
          res_push           = 1'b1;
          res.last_of_run    = 1'b1;
          hold_valid_next    = 1'b0;
        end
        if (!cmd_empty && (!hold_valid || !res_full)) begin
          cmd_pop = 1'b1;
          if (cmd.frame_start) begin
            run_pending_next = 1'b0;
            run_length_next  = '0;
            pos_next         = '0;
            plane_next       = '0;
            rows_done_next   = '0;
          end
          if (rows_eff < eff_h) begin
            priority if (pend_eff) begin
              run_pending_next = 1'b0;
              run_length_next  = '0;
              cur_byte_next    = cmd.data_byte;
              remaining_next   = rlen_eff;
              if (rlen_eff != '0) begin
                state_next = ST_RUN;
              end
            end else if (cmd.is_marker) begin
              run_pending_next = 1'b1;
              run_length_next  = cmd.data_byte[5:0] & RUN_LEN_MASK;
            end else begin
              cur_byte_next  = cmd.data_byte;
              remaining_next = 6'd1;
              state_next     = ST_RUN;
            end
          end
        end
      end
      ST_RUN: begin
        if (!res_full) begin
          if (cfg.three_planes && plane[1]) begin
            state_next = ST_BLUE;
          end else begin
            place    = 1'b1;
            new_made = !cfg.three_planes && mono_made;
            new_res  = mono_res;
          end
        end
      end
      ST_BLUE: begin
        if (!res_full) begin
          place    = 1'b1;
          new_made = blue_made;
          new_res  = blue_res;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (place) begin
      pos_next       = pos_adv;
      plane_next     = plane_adv;
      rows_done_next = rows_adv;
      remaining_next = remaining - 6'd1;
      if (new_made) begin
        if (hold_valid) begin
          res_push = 1'b1;
        end
        hold_valid_next = 1'b1;
        hold_next       = new_res;
      end
      state_next = ((remaining == 6'd1) || (rows_adv >= eff_h)) ? ST_IDLE : ST_RUN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      run_pending <= 1'b0;
      run_length  <= '0;
      pos         <= '0;
      plane       <= '0;
      rows_done   <= '0;
      hold_valid  <= 1'b0;
    end else begin
      state       <= state_next;
      run_pending <= run_pending_next;
      run_length  <= run_length_next;
      pos         <= pos_next;
      plane       <= plane_next;
      rows_done   <= rows_done_next;
      hold_valid  <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    remaining <= remaining_next;
    cur_byte  <= cur_byte_next;
    hold      <= hold_next;
  end

  // scanline stores for the red and green planes
  assign ram_addr   = AW'(pos);
  assign pos_in_ram = (32'(pos) < MAX_WIDTH);
  assign red_we     = place && (state == ST_RUN) && cfg.three_planes &&
                      (plane == 2'd0) && pos_in_ram;
  assign green_we   = place && (state == ST_RUN) && cfg.three_planes &&
                      (plane == 2'd1) && pos_in_ram;

  prd_ram #(
    .WIDTH(8),
    .DEPTH(MAX_WIDTH)
  ) u_red_line (
    .clk  (clk),
    .we   (red_we),
    .waddr(ram_addr),
    .wdata(cur_byte),
    .raddr(ram_addr),
    .rdata(red_q)
  );

  prd_ram #(
    .WIDTH(8),
    .DEPTH(MAX_WIDTH)
  ) u_green_line (
    .clk  (clk),
    .we   (green_we),
    .waddr(ram_addr),
    .wdata(cur_byte),
    .raddr(ram_addr),
    .rdata(green_q)
  );

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN || state == ST_BLUE) |-> (remaining != 6'd0))
    else $error("run active with no repeats left");

  a_push_has_hold: assert property (@(posedge clk) disable iff (rst)
    res_push |-> hold_valid)
    else $error("result pushed with nothing held");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_blue_mode: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BLUE) |-> (cfg.three_planes && plane[1]))
    else $error("blue fetch outside blue plane");

  a_idle_flush_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && res_push) |-> res.last_of_run)
    else $error("final result of an item not marked last");

endmodule

@@ sv/pcx_rle_pixel_decoder_unit.sv @@
`timescale 1ns / 1ps
// PCX run-length pixel decoder.
// Input channel: push/full with stream (data_byte, frame_start); a byte is
// taken when push is high and full is low. A four-entry command queue sits
// in front of the decode sequencer.
// Result channel: empty/pop with pixels; the oldest result is shown while
// empty is low and leaves when pop is high. A two-entry result queue parts
// the sequencer from the receiver, so a stalled receiver only stops the
// sequencer once that queue is full.
// Config channel: cfg_valid/cfg_ready (always ready), cfg_index, cfg_data;
// write only while no item is in flight.
// Sequencing: a marker byte is taken in the idle state alone; a literal
// is taken in idle and placed in the run state, and a run places its byte
// once per repeat in the run state; a new byte is taken only in idle. In
// three-plane mode each blue byte passes through an extra blue state for
// the registered read of the red and green line stores. Each result waits
// in a hold register so the final one of a byte can be marked last_of_run.
// Reset clears the queues and the decode position and sets the config registers
// to their defaults; the line stores are not cleared.
module pcx_rle_pixel_decoder_unit #(
  parameter int MAX_WIDTH       = 4096,
  parameter int MAX_PLANE_BYTES = 4096,
  parameter int MAX_HEIGHT      = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  prd_pkg::in_t  stream,
  output logic          empty,
  input  logic          pop,
  output prd_pkg::out_t pixels,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [12:0]   cfg_data
);
  import prd_pkg::*;

  localparam int RES_DEPTH = 2;

  cfg_t cfg;
  cmd_t cmd;
  logic cmd_empty;
  logic cmd_pop;
  logic res_full;
  logic res_push;
  out_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.depth_code      <= 2'd3;
      cfg.three_planes    <= 1'b0;
      cfg.bytes_per_plane <= 13'd1;
      cfg.image_width     <= 13'd1;
      cfg.image_height    <= 13'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEPTH_CODE:      cfg.depth_code      <= cfg_data[1:0];
        CFG_THREE_PLANES:    cfg.three_planes    <= cfg_data[0];
        CFG_BYTES_PER_PLANE: cfg.bytes_per_plane <= cfg_data;
        CFG_IMAGE_WIDTH:     cfg.image_width     <= cfg_data;
        CFG_IMAGE_HEIGHT:    cfg.image_height    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  prd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .stream   (stream),
    .cmd_pop  (cmd_pop),
    .cmd_empty(cmd_empty),
    .cmd      (cmd)
  );

  prd_back #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_PLANE_BYTES(MAX_PLANE_BYTES),
    .MAX_HEIGHT     (MAX_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd_empty(cmd_empty),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  prd_fifo #(
    .WIDTH($bits(out_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res),
    .full (res_full),
    .pop  (pop),
    .dout (pixels),
    .empty(empty)
  );

endmodule
